/* rtl/rlp_pkg.sv */
// Package for the repeat label packer: widths, register map, payload and
// control structs, label lookup helper. No dependencies.
package rlp_pkg;

  localparam int MaxRepLimit = 4;
  localparam int TokenBits   = 16;

  localparam int TokenW      = 16;
  localparam int CountW      = 3;
  localparam int LabelCount  = 4;
  localparam int LabelIdxW   = 2;
  localparam int LimCap      = (MaxRepLimit < LabelCount) ? MaxRepLimit : LabelCount;
  localparam logic [TokenW-1:0] TokMask =
      (TokenBits >= TokenW) ? {TokenW{1'b1}} : TokenW'((64'd1 << TokenBits) - 64'd1);

  // APB register map
  localparam int AddrW = 5;
  localparam int DataW = 32;
  localparam logic [2:0] RegMaxReps    = 3'd0;
  localparam logic [2:0] RegLabelOne   = 3'd1;
  localparam logic [2:0] RegLabelTwo   = 3'd2;
  localparam logic [2:0] RegLabelThree = 3'd3;
  localparam logic [2:0] RegLabelFour  = 3'd4;

  // Output buffer
  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;
  localparam int FifoCntW  = 3;

  typedef struct packed {
    logic [TokenW-1:0] token_in;
    logic              seq_end;
  } rlp_item_t;

  typedef struct packed {
    logic [TokenW-1:0] token_out;
    logic              out_last;
  } rlp_word_t;

  typedef struct packed {
    logic [CountW-1:0]                 max_reps;
    logic [LabelCount-1:0][TokenW-1:0] labels;
  } rlp_cfg_t;

  // Up to two words pushed into the output buffer per item
  typedef struct packed {
    logic [1:0] cnt;
    rlp_word_t  w0;
    rlp_word_t  w1;
  } rlp_push_t;

  // Repeat count 1..4 to label slot 0..3, larger counts use the last slot
  function automatic logic [LabelIdxW-1:0] rlp_label_idx(input logic [CountW-1:0] count);
    logic [LabelIdxW-1:0] idx;
    if (count > CountW'(LabelCount)) begin
      idx = LabelIdxW'(LabelCount - 1);
    end else if (count == '0) begin
      idx = '0;
    end else begin
      idx = LabelIdxW'(count - CountW'(1));
    end
    return idx;
  endfunction

endpackage

/* rtl/rlp_stream_if.sv */
// Valid/ready stream interfaces for input items and result words.
// Depends on rlp_pkg for field widths.
interface rlp_in_if;
  import rlp_pkg::*;
  logic              valid;
  logic              ready;
  logic [TokenW-1:0] token_in;
  logic              seq_end;
  modport source(output valid, token_in, seq_end, input ready);
  modport sink(input valid, token_in, seq_end, output ready);
endinterface

interface rlp_out_if;
  import rlp_pkg::*;
  logic              valid;
  logic              ready;
  logic [TokenW-1:0] token_out;
  logic              out_last;
  modport source(output valid, token_out, out_last, input ready);
  modport sink(input valid, token_out, out_last, output ready);
endinterface

/* rtl/rlp_cfg_regs.sv */
// APB configuration registers: repeat limit and the four repeat labels.
// Depends on rlp_pkg.
module rlp_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rlp_pkg::AddrW-1:0] paddr,
  input  logic [rlp_pkg::DataW-1:0] pwdata,
  output logic [rlp_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output rlp_pkg::rlp_cfg_t         cfg_o
);
  import rlp_pkg::*;

  rlp_cfg_t   cfg_q, cfg_d;
  logic [2:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        RegMaxReps:    cfg_d.max_reps  = pwdata[CountW-1:0];
        RegLabelOne:   cfg_d.labels[0] = pwdata[TokenW-1:0];
        RegLabelTwo:   cfg_d.labels[1] = pwdata[TokenW-1:0];
        RegLabelThree: cfg_d.labels[2] = pwdata[TokenW-1:0];
        RegLabelFour:  cfg_d.labels[3] = pwdata[TokenW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      RegMaxReps:    prdata = DataW'(cfg_q.max_reps);
      RegLabelOne:   prdata = DataW'(cfg_q.labels[0]);
      RegLabelTwo:   prdata = DataW'(cfg_q.labels[1]);
      RegLabelThree: prdata = DataW'(cfg_q.labels[2]);
      RegLabelFour:  prdata = DataW'(cfg_q.labels[3]);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/rlp_core.sv */
// Input register and run-length decision: absorbs repeats, emits labels
// and tokens as up to two words per item. Depends on rlp_pkg.
module rlp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  rlp_pkg::rlp_item_t in_item_i,
  output logic               in_ready_o,
  input  rlp_pkg::rlp_cfg_t  cfg_i,
  input  logic               space_ok_i,
  output rlp_pkg::rlp_push_t push_o
);
  import rlp_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  rlp_item_t         s1_item_q;
  logic              s1_fire;
  logic              in_fire;

  logic [TokenW-1:0] prev_q, prev_d;
  logic              have_prev_q, have_prev_d;
  logic [CountW-1:0] count_q, count_d;

  logic [TokenW-1:0] tok;
  logic [CountW-1:0] lim;
  logic [CountW-1:0] count_inc;
  logic              absorb;

  // Item enters when the stage is empty or drains this cycle
  assign s1_fire    = s1_valid_q & space_ok_i;
  assign in_ready_o = ~s1_valid_q | s1_fire;
  assign in_fire    = in_valid_i & in_ready_o;
  assign s1_valid_d = in_fire | (s1_valid_q & ~s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item_i;
    end
  end

  // Effective limit: capped by the label count and the build limit
  assign lim       = (cfg_i.max_reps > CountW'(LimCap)) ? CountW'(LimCap) : cfg_i.max_reps;
  assign tok       = s1_item_q.token_in & TokMask;
  assign absorb    = have_prev_q & (tok == prev_q) & (count_q < lim);
  assign count_inc = count_q + CountW'(1);

  // Decide the words and the next run state
  always_comb begin
    push_o      = '0;
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    count_d     = count_q;
    if (s1_fire) begin
      if (absorb) begin
        count_d = count_inc;
        if (s1_item_q.seq_end) begin
          push_o.cnt          = 2'd1;
          push_o.w0.token_out = cfg_i.labels[rlp_label_idx(count_inc)];
          push_o.w0.out_last  = 1'b1;
        end
      end else begin
        if (count_q != '0) begin
          push_o.cnt          = 2'd2;
          push_o.w0.token_out = cfg_i.labels[rlp_label_idx(count_q)];
          push_o.w0.out_last  = 1'b0;
          push_o.w1.token_out = tok;
          push_o.w1.out_last  = s1_item_q.seq_end;
        end else begin
          push_o.cnt          = 2'd1;
          push_o.w0.token_out = tok;
          push_o.w0.out_last  = s1_item_q.seq_end;
        end
        count_d     = '0;
        prev_d      = tok;
        have_prev_d = 1'b1;
      end
      // Clear the run at the end of a sequence
      if (s1_item_q.seq_end) begin
        prev_d      = '0;
        have_prev_d = 1'b0;
        count_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      count_q     <= '0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      count_q     <= count_d;
    end
  end

endmodule

/* rtl/rlp_out_fifo.sv */
// Four-word result buffer taking up to two words a cycle while it reports room for a pair, giving one.
// Depends on rlp_pkg.
module rlp_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rlp_pkg::rlp_push_t push_i,
  output logic               space_ok_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rlp_pkg::rlp_word_t out_word_o
);
  import rlp_pkg::*;

  rlp_word_t           mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [FifoAw-1:0]   wr_ptr_nxt;
  logic                pop;

  // Room for a full pair, judged before this cycle's pop
  assign space_ok_o  = cnt_q <= FifoCntW'(FifoDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_word_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  assign wr_ptr_nxt  = wr_ptr_q + FifoAw'(1);

  assign wr_ptr_d = wr_ptr_q + FifoAw'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + FifoAw'(pop);
  assign cnt_d    = cnt_q + FifoCntW'(push_i.cnt) - FifoCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed words
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.w0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.w1;
    end
  end

endmodule

/* rtl/repeat_label_packer.sv */
// Repeat label packer top level: input register, run decision, result buffer.
// Path: an accepted item is held in the input register, then its words are written into the result buffer.
// Throughput: one item per cycle when each yields at most one word and the receiver does not stall; an
// item giving a label and a token holds the single output port for both words.
// Reset: asynchronous active low, clears run state, buffer and registers.
// Depends on rlp_pkg, rlp_stream_if, rlp_cfg_regs, rlp_core, rlp_out_fifo.
module repeat_label_packer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rlp_in_if.sink                    in_i,
  rlp_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rlp_pkg::AddrW-1:0] paddr,
  input  logic [rlp_pkg::DataW-1:0] pwdata,
  output logic [rlp_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import rlp_pkg::*;

  rlp_cfg_t  cfg;
  rlp_item_t in_item;
  rlp_push_t push;
  rlp_word_t out_word;
  logic      space_ok;
  logic      in_ready;
  logic      out_valid;

  assign in_item.token_in = in_i.token_in;
  assign in_item.seq_end  = in_i.seq_end;
  assign in_i.ready       = in_ready;

  rlp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rlp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_item_i  (in_item),
    .in_ready_o (in_ready),
    .cfg_i      (cfg),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  rlp_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

  assign out_o.valid     = out_valid;
  assign out_o.token_out = out_word.token_out;
  assign out_o.out_last  = out_word.out_last;

`ifndef SYNTHESIS
  // Never push more than a label and a token
  assert property (@(posedge clk_i) disable iff (!rst_ni) push.cnt != 2'd3)
    else $error("push count out of range");

  // Push only when the buffer reported room for a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni) (push.cnt != 2'd0) |-> space_ok)
    else $error("push into full result buffer");

  // After any push the buffer shows a word on the output next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (push.cnt != 2'd0) |=> out_o.valid)
    else $error("pushed word not presented");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for repeat_label_packer: directed token table,
// then random token sequences under several idle patterns, register writes.
// Depends on rlp_pkg, rlp_stream_if and the repeat_label_packer RTL.
`timescale 1ns / 1ps

module tb;
  import rlp_pkg::*;

  localparam int RUN_LIMIT    = 300000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 163;
  localparam logic [TokenW-1:0] TOK_KEEP = TokenW'((64'd1 << TokenBits) - 64'd1);

  // Idle patterns, cycled over the random phases
  localparam int SEND_IDLE [4]  = '{0, 80, 0, 11};
  localparam int RECV_STALL [4] = '{0, 0, 80, 11};
  localparam int MAX_PLAN [8]   = '{4, 0, 2, 7, 1, 3, 4, 5};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [2:0]        reg_sel;
    logic [TokenW-1:0] value;
    logic              last;
    logic              typed;
    logic [1:0]        n;
    rlp_word_t         e0;
    rlp_word_t         e1;
  } step_row_t;

  localparam rlp_word_t NO_WORD = '0;

  // Directed rows: register writes, and items with hand-typed results where obvious
  localparam step_row_t DIRECTED [32] = '{
    // after reset: pass-through, first token zero is never absorbed
    '{ROW_ITEM, 3'd0, 16'h0000, 1'b0, 1'b1, 2'd1, '{16'h0000, 1'b0}, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0000, 1'b0, 1'b1, 2'd1, '{16'h0000, 1'b0}, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'hFFFF, 1'b1, 1'b1, 2'd1, '{16'hFFFF, 1'b1}, NO_WORD},
    '{ROW_CFG, RegLabelOne,   16'hFFFF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_CFG, RegLabelTwo,   16'h0000, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_CFG, RegLabelThree, 16'hA5A5, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_CFG, RegLabelFour,  16'h5A5A, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_CFG, RegMaxReps,    16'h0004, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    // full run of four, a fifth repeat spills the label
    '{ROW_ITEM, 3'd0, 16'h0007, 1'b0, 1'b1, 2'd1, '{16'h0007, 1'b0}, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0007, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0007, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0007, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0007, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0007, 1'b0, 1'b1, 2'd2, '{16'h5A5A, 1'b0}, '{16'h0007, 1'b0}},
    // final token absorbed: label alone, marked last
    '{ROW_ITEM, 3'd0, 16'h0007, 1'b1, 1'b1, 2'd1, '{16'hFFFF, 1'b1}, NO_WORD},
    // final token not absorbed: label then token
    '{ROW_ITEM, 3'd0, 16'h8000, 1'b0, 1'b1, 2'd1, '{16'h8000, 1'b0}, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h8000, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0001, 1'b1, 1'b1, 2'd2, '{16'hFFFF, 1'b0}, '{16'h0001, 1'b1}},
    // lower the limit while a count of two is pending
    '{ROW_ITEM, 3'd0, 16'h0003, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0003, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0003, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_CFG, RegMaxReps,    16'h0001, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0003, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0003, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    // oversized limit acts as four
    '{ROW_CFG, RegMaxReps,    16'h0007, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0009, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0009, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0009, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0009, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0009, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{ROW_ITEM, 3'd0, 16'h0009, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    // state cleared: same token starts the next sequence
    '{ROW_ITEM, 3'd0, 16'h0009, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD}
  };

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  rlp_in_if  in_if ();
  rlp_out_if out_if ();

  repeat_label_packer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Packer state and register copy for prediction
  logic [CountW-1:0] cfg_max;
  logic [TokenW-1:0] cfg_label [LabelCount];
  logic [TokenW-1:0] last_tok;
  logic              have_last;
  logic [CountW-1:0] run_cnt;

  rlp_word_t want_words [$];
  rlp_word_t head;
  int        mismatches;
  int        idle_pct;
  int        stall_pct;
  int        cycle_cnt;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [TokenW-1:0] label_of(input logic [CountW-1:0] count);
    int slot;
    if (count == '0) begin
      return '0;
    end
    slot = (int'(count) > LabelCount) ? LabelCount : int'(count);
    return cfg_label[slot - 1];
  endfunction

  // Predict the words one token causes, and advance the run state
  function automatic int pack_step(input rlp_item_t it, output rlp_word_t w [2]);
    logic [TokenW-1:0] tok;
    int                lim;
    int                n;
    tok = it.token_in & TOK_KEEP;
    n   = 0;
    w[0] = NO_WORD;
    w[1] = NO_WORD;
    lim = int'(cfg_max);
    if (lim > MaxRepLimit) lim = MaxRepLimit;
    if (lim > LabelCount) lim = LabelCount;
    if (have_last && tok == last_tok && int'(run_cnt) < lim) begin
      run_cnt = run_cnt + 1'b1;
      if (it.seq_end) begin
        w[n] = '{label_of(run_cnt), 1'b1};
        n++;
      end
    end else begin
      if (run_cnt != '0) begin
        w[n] = '{label_of(run_cnt), 1'b0};
        n++;
        run_cnt = '0;
      end
      w[n] = '{tok, it.seq_end};
      n++;
      last_tok  = tok;
      have_last = 1'b1;
    end
    if (it.seq_end) begin
      last_tok  = '0;
      have_last = 1'b0;
      run_cnt   = '0;
    end
    return n;
  endfunction

  // Append one predicted word behind the ones still outstanding
  task automatic want_word(input rlp_word_t w);
    want_words = {want_words, w};
  endtask

  // Offer one token after a random gap, hold until accepted, predict its words
  task automatic push_item(input logic [TokenW-1:0] tok, input logic last,
                           output int n, output rlp_word_t w [2]);
    rlp_item_t it;
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.token_in <= tok;
    in_if.seq_end  <= last;
    do @(posedge clk); while (!in_if.ready);
    it.token_in = tok;
    it.seq_end  = last;
    n = pack_step(it, w);
  endtask

  // Hold input, wait until all words are out, let absorbed tokens settle
  task automatic drain_words();
    in_if.valid <= 1'b0;
    while (want_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register while idle, then read it back
  task automatic reg_write(input logic [2:0] idx, input logic [TokenW-1:0] value);
    logic [DataW-1:0] rd_want;
    drain_words();
    rd_want = (idx == RegMaxReps) ? DataW'(value[CountW-1:0]) : DataW'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= DataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == RegMaxReps) begin
      cfg_max = value[CountW-1:0];
    end else begin
      cfg_label[int'(idx) - 1] = value;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== rd_want) begin
      $error("prdata reg %0d: expected %h, got %h", idx, rd_want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drive receiver ready and check every accepted word against the oldest prediction
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_if.valid && out_if.ready) begin
      if (want_words.size() == 0) begin
        $error("unexpected word: token_out %h out_last %b", out_if.token_out, out_if.out_last);
        mismatches++;
      end else begin
        head = want_words.pop_front();
        if (out_if.token_out !== head.token_out) begin
          $error("token_out: expected %h, got %h", head.token_out, out_if.token_out);
          mismatches++;
        end
        if (out_if.out_last !== head.out_last) begin
          $error("out_last: expected %b, got %b", head.out_last, out_if.out_last);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    step_row_t         row;
    rlp_word_t         w [2];
    int                n;
    int                len;
    int                sent;
    int                r;
    logic [TokenW-1:0] pool [3];
    logic [TokenW-1:0] tok;
    logic [TokenW-1:0] lbl;

    mismatches     = 0;
    cycle_cnt      = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    cfg_max        = '0;
    last_tok       = '0;
    have_last      = 1'b0;
    run_cnt        = '0;
    foreach (cfg_label[i]) cfg_label[i] = '0;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_if.valid    = 1'b0;
    in_if.token_in = '0;
    in_if.seq_end  = 1'b0;
    out_if.ready   = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        reg_write(row.reg_sel, row.value);
      end else begin
        push_item(row.value, row.last, n, w);
        if (row.typed) begin
          if (row.n > 0) want_word(row.e0);
          if (row.n > 1) want_word(row.e1);
        end else begin
          for (int k = 0; k < n; k++) want_word(w[k]);
        end
      end
    end

    // Random phases: new settings, then runs of repeated tokens with some noise
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(RegMaxReps, TokenW'(MAX_PLAN[ph]));
      for (int k = 1; k <= LabelCount; k++) begin
        lbl = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                       : TokenW'($urandom);
        reg_write(3'(k), lbl);
      end
      idle_pct  = SEND_IDLE[ph % 4];
      stall_pct = RECV_STALL[ph % 4];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 14);
        foreach (pool[p]) pool[p] = TokenW'($urandom);
        if ($urandom_range(9) == 0) pool[0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        tok = pool[$urandom_range(2)];
        for (int k = 0; k < len; k++) begin
          if (k > 0) begin
            r = $urandom_range(99);
            if (r >= 60 && r < 92) begin
              tok = pool[$urandom_range(2)];
            end else if (r >= 92) begin
              tok = TokenW'($urandom);
            end
          end
          push_item(tok, k == len - 1, n, w);
          for (int j = 0; j < n; j++) want_word(w[j]);
          sent++;
        end
      end
    end

    // Let the last words drain, then report
    idle_pct  = 0;
    stall_pct = 0;
    drain_words();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* repeat_label_packer.f */
rtl/rlp_pkg.sv
rtl/rlp_stream_if.sv
rtl/rlp_cfg_regs.sv
rtl/rlp_core.sv
rtl/rlp_out_fifo.sv
rtl/repeat_label_packer.sv
tb/tb.sv
